// ===== hdl/fcsg_pkg.sv =====
package fcsg_pkg;

   localparam int COORD_W = 10;
   localparam int RAD_W   = 6;
   localparam int COLOR_W = 8;
   localparam int X_W     = 12;
   localparam int Y_W     = 11;
   localparam int LEN_W   = 7;
   localparam int ACC_W   = 10;

   localparam logic signed [ACC_W-1:0] F_INIT   = ACC_W'(1);
   localparam logic signed [ACC_W-1:0] DDX_INIT = ACC_W'(1);
   localparam logic signed [ACC_W-1:0] D_STEP   = ACC_W'(2);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic zero_radius;
      logic done;
   } status_type;

endpackage

// ===== hdl/fcsg_ctrl.sv =====
module fcsg_ctrl
   import fcsg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && start;
      cmd.step = (state_ff == ST_RUN);
      valid_in = cmd.load || cmd.step;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !status.zero_radius) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff == ST_RUN);
   assign rsp_valid = valid_ff;

endmodule

// ===== hdl/fcsg_datapath.sv =====
module fcsg_datapath
   import fcsg_pkg::*;
#(
   parameter int MAX_RADIUS = 63,
   parameter int COORD_BITS = 10
)
(
   input  logic                    clock,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [COORD_W-1:0]      req_center_x,
   input  logic [COORD_W-1:0]      req_center_y,
   input  logic [RAD_W-1:0]        req_radius,
   input  logic [COLOR_W-1:0]      req_color,
   output logic signed [X_W-1:0]   rsp_right_x_a,
   output logic signed [X_W-1:0]   rsp_left_x_a,
   output logic signed [Y_W-1:0]   rsp_top_a,
   output logic [LEN_W-1:0]        rsp_length_a,
   output logic signed [X_W-1:0]   rsp_right_x_b,
   output logic signed [X_W-1:0]   rsp_left_x_b,
   output logic signed [Y_W-1:0]   rsp_top_b,
   output logic [LEN_W-1:0]        rsp_length_b,
   output logic [COLOR_W-1:0]      rsp_span_color,
   output logic                    rsp_last
);

   localparam int RMAX = (MAX_RADIUS > 63) ? 63 : MAX_RADIUS;
   localparam logic [COORD_W-1:0] CMASK =
      (COORD_BITS >= COORD_W) ? {COORD_W{1'b1}} : COORD_W'((1 << COORD_BITS) - 1);

   logic [COORD_W-1:0]      cx_ff, cy_ff, cx_in, cy_in;
   logic [COLOR_W-1:0]      col_ff;
   logic signed [ACC_W-1:0] f_ff, ddx_ff, ddy_ff;
   logic [RAD_W-1:0]        a_ff, b_ff;
   logic [RAD_W-1:0]        r_sat;

   logic signed [ACC_W-1:0] f_in, ddx_in, ddy_in, ddy_p2, f_add;
   logic [RAD_W-1:0]        a_in, b_in;
   logic                    take;

   logic signed [X_W-1:0]   rxa_in, lxa_in, rxb_in, lxb_in;
   logic signed [Y_W-1:0]   ta_in, tb_in;
   logic [LEN_W-1:0]        la_in, lb_in;
   logic                    last_in;

   logic signed [X_W-1:0]   rxa_ff, lxa_ff, rxb_ff, lxb_ff;
   logic signed [Y_W-1:0]   ta_ff, tb_ff;
   logic [LEN_W-1:0]        la_ff, lb_ff;
   logic                    last_ff;

   always_comb begin
      r_sat = (int'(req_radius) > RMAX) ? RAD_W'(RMAX) : req_radius;
      cx_in = req_center_x & CMASK;
      cy_in = req_center_y & CMASK;

      take   = !f_ff[ACC_W-1];
      ddy_p2 = ddy_ff + D_STEP;
      ddx_in = ddx_ff + D_STEP;
      ddy_in = take ? ddy_p2 : ddy_ff;
      f_add  = take ? ddy_p2 : '0;
      f_in   = f_ff + f_add + ddx_in;
      a_in   = a_ff + RAD_W'(1);
      b_in   = take ? (b_ff - RAD_W'(1)) : b_ff;

      status.zero_radius = (r_sat == '0);
      status.done        = !(a_in < b_in);

      if (cmd.load) begin
         rxa_in  = X_W'(cx_in);
         lxa_in  = X_W'(cx_in);
         ta_in   = Y_W'(cy_in) - Y_W'(r_sat);
         la_in   = {r_sat, 1'b1};
         rxb_in  = '0;
         lxb_in  = '0;
         tb_in   = '0;
         lb_in   = '0;
         last_in = status.zero_radius;
      end else begin
         rxa_in  = X_W'(cx_ff) + X_W'(a_in);
         lxa_in  = X_W'(cx_ff) - X_W'(a_in);
         ta_in   = Y_W'(cy_ff) - Y_W'(b_in);
         la_in   = {b_in, 1'b1};
         rxb_in  = X_W'(cx_ff) + X_W'(b_in);
         lxb_in  = X_W'(cx_ff) - X_W'(b_in);
         tb_in   = Y_W'(cy_ff) - Y_W'(a_in);
         lb_in   = {a_in, 1'b1};
         last_in = status.done;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff  <= cx_in;
         cy_ff  <= cy_in;
         col_ff <= req_color;
         f_ff   <= F_INIT - ACC_W'(r_sat);
         ddx_ff <= DDX_INIT;
         ddy_ff <= -ACC_W'({r_sat, 1'b0});
         a_ff   <= '0;
         b_ff   <= r_sat;
      end else if (cmd.step) begin
         f_ff   <= f_in;
         ddx_ff <= ddx_in;
         ddy_ff <= ddy_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
      end
      if (cmd.load || cmd.step) begin
         rxa_ff  <= rxa_in;
         lxa_ff  <= lxa_in;
         ta_ff   <= ta_in;
         la_ff   <= la_in;
         rxb_ff  <= rxb_in;
         lxb_ff  <= lxb_in;
         tb_ff   <= tb_in;
         lb_ff   <= lb_in;
         last_ff <= last_in;
      end
   end

   assign rsp_right_x_a  = rxa_ff;
   assign rsp_left_x_a   = lxa_ff;
   assign rsp_top_a      = ta_ff;
   assign rsp_length_a   = la_ff;
   assign rsp_right_x_b  = rxb_ff;
   assign rsp_left_x_b   = lxb_ff;
   assign rsp_top_b      = tb_ff;
   assign rsp_length_b   = lb_ff;
   assign rsp_span_color = col_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== hdl/filled_circle_span_generator_unit.sv =====
// The first span result is shown in the cycle after a request is accepted.
// Throughput: one result per cycle from the midpoint step loop; a circle gives one
// result for the center column plus one per midpoint iteration.
// A new request is taken in the cycle the last result is shown; the receiver cannot stall.
// Reset (synchronous, active high) returns the controller to idle and drops the strobe.
module filled_circle_span_generator_unit
   import fcsg_pkg::*;
#(
   parameter int MAX_RADIUS = 63,
   parameter int COORD_BITS = 10
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [COORD_W-1:0]      req_center_x,
   input  logic [COORD_W-1:0]      req_center_y,
   input  logic [RAD_W-1:0]        req_radius,
   input  logic [COLOR_W-1:0]      req_color,
   output logic                    rsp_valid,
   output logic signed [X_W-1:0]   rsp_right_x_a,
   output logic signed [X_W-1:0]   rsp_left_x_a,
   output logic signed [Y_W-1:0]   rsp_top_a,
   output logic [LEN_W-1:0]        rsp_length_a,
   output logic signed [X_W-1:0]   rsp_right_x_b,
   output logic signed [X_W-1:0]   rsp_left_x_b,
   output logic signed [Y_W-1:0]   rsp_top_b,
   output logic [LEN_W-1:0]        rsp_length_b,
   output logic [COLOR_W-1:0]      rsp_span_color,
   output logic                    rsp_last
);

   cmd_type    cmd;
   status_type status;

   fcsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fcsg_datapath #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius     (req_radius),
      .req_color      (req_color),
      .rsp_right_x_a  (rsp_right_x_a),
      .rsp_left_x_a   (rsp_left_x_a),
      .rsp_top_a      (rsp_top_a),
      .rsp_length_a   (rsp_length_a),
      .rsp_right_x_b  (rsp_right_x_b),
      .rsp_left_x_b   (rsp_left_x_b),
      .rsp_top_b      (rsp_top_b),
      .rsp_length_b   (rsp_length_b),
      .rsp_span_color (rsp_span_color),
      .rsp_last       (rsp_last)
   );

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("last span shown while still busy");

   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final span shown while idle");

   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) || $past(start && !busy))
      else $error("span strobe without request or step");

   // the center column carries a zero second length, so growth starts after it
   a_lenb_grow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && $past(busy) && ($past(rsp_length_b) != '0) |->
         rsp_length_b == $past(rsp_length_b) + LEN_W'(2))
      else $error("second pair length did not advance by two");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
   import fcsg_pkg::*;
();

   localparam int MAX_RADIUS   = 63;
   localparam int COORD_BITS   = 10;
   localparam int RANDOM_COUNT = 350;
   localparam int TAIL_CYCLES  = 60;

   typedef struct packed {
      logic signed [X_W-1:0] right_x_a;
      logic signed [X_W-1:0] left_x_a;
      logic signed [Y_W-1:0] top_a;
      logic [LEN_W-1:0]      length_a;
      logic signed [X_W-1:0] right_x_b;
      logic signed [X_W-1:0] left_x_b;
      logic signed [Y_W-1:0] top_b;
      logic [LEN_W-1:0]      length_b;
      logic [COLOR_W-1:0]    span_color;
      logic                  last;
   } span_type;

   class span_scoreboard;
      span_type expected_spans[$];
      int       mismatches;
      int       spans_checked;

      function new();
         mismatches    = 0;
         spans_checked = 0;
      endfunction

      function void push_span(int rxa, int lxa, int ta, int la, int rxb, int lxb, int tb_y,
                              int lb, int col, bit is_last);
         span_type s;
         s.right_x_a  = X_W'(rxa);
         s.left_x_a   = X_W'(lxa);
         s.top_a      = Y_W'(ta);
         s.length_a   = LEN_W'(la);
         s.right_x_b  = X_W'(rxb);
         s.left_x_b   = X_W'(lxb);
         s.top_b      = Y_W'(tb_y);
         s.length_b   = LEN_W'(lb);
         s.span_color = COLOR_W'(col);
         s.last       = is_last;
         expected_spans.push_back(s);
      endfunction

      // midpoint recurrence over the disc, center column first
      function void note_request(int cx, int cy, int r, int col);
         int f;
         int ddx;
         int ddy;
         int a;
         int b;
         if (r > MAX_RADIUS) begin
            r = MAX_RADIUS;
         end
         push_span(cx, cx, cy - r, 2 * r + 1, 0, 0, 0, 0, col, r <= 0);
         f   = 1 - r;
         ddx = 1;
         ddy = -2 * r;
         a   = 0;
         b   = r;
         while (a < b) begin
            if (f >= 0) begin
               b   = b - 1;
               ddy = ddy + 2;
               f   = f + ddy;
            end
            a   = a + 1;
            ddx = ddx + 2;
            f   = f + ddx;
            push_span(cx + a, cx - a, cy - b, 2 * b + 1, cx + b, cx - b, cy - a, 2 * a + 1,
                      col, !(a < b));
         end
      endfunction

      function void compare_field(string fname, int want, int got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
         end
      endfunction

      function void check_span(span_type got);
         span_type want;
         if (expected_spans.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected span result, expected none, got %p", $time, got);
            return;
         end
         want = expected_spans.pop_front();
         spans_checked++;
         compare_field("right_x_a", int'(want.right_x_a), int'(got.right_x_a));
         compare_field("left_x_a", int'(want.left_x_a), int'(got.left_x_a));
         compare_field("top_a", int'(want.top_a), int'(got.top_a));
         compare_field("length_a", int'(want.length_a), int'(got.length_a));
         compare_field("right_x_b", int'(want.right_x_b), int'(got.right_x_b));
         compare_field("left_x_b", int'(want.left_x_b), int'(got.left_x_b));
         compare_field("top_b", int'(want.top_b), int'(got.top_b));
         compare_field("length_b", int'(want.length_b), int'(got.length_b));
         compare_field("span_color", int'(want.span_color), int'(got.span_color));
         compare_field("last", int'(want.last), int'(got.last));
      endfunction

      function int pending();
         return expected_spans.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [COORD_W-1:0]    req_center_x;
   logic [COORD_W-1:0]    req_center_y;
   logic [RAD_W-1:0]      req_radius;
   logic [COLOR_W-1:0]    req_color;
   logic                  rsp_valid;
   logic signed [X_W-1:0] rsp_right_x_a;
   logic signed [X_W-1:0] rsp_left_x_a;
   logic signed [Y_W-1:0] rsp_top_a;
   logic [LEN_W-1:0]      rsp_length_a;
   logic signed [X_W-1:0] rsp_right_x_b;
   logic signed [X_W-1:0] rsp_left_x_b;
   logic signed [Y_W-1:0] rsp_top_b;
   logic [LEN_W-1:0]      rsp_length_b;
   logic [COLOR_W-1:0]    rsp_span_color;
   logic                  rsp_last;

   span_scoreboard spans;
   int             circles_sent;
   int             zero_radius_sent;
   int             full_radius_sent;

   filled_circle_span_generator_unit #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius     (req_radius),
      .req_color      (req_color),
      .rsp_valid      (rsp_valid),
      .rsp_right_x_a  (rsp_right_x_a),
      .rsp_left_x_a   (rsp_left_x_a),
      .rsp_top_a      (rsp_top_a),
      .rsp_length_a   (rsp_length_a),
      .rsp_right_x_b  (rsp_right_x_b),
      .rsp_left_x_b   (rsp_left_x_b),
      .rsp_top_b      (rsp_top_b),
      .rsp_length_b   (rsp_length_b),
      .rsp_span_color (rsp_span_color),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) begin
      span_type got;
      if (!reset && rsp_valid === 1'b1) begin
         got.right_x_a  = rsp_right_x_a;
         got.left_x_a   = rsp_left_x_a;
         got.top_a      = rsp_top_a;
         got.length_a   = rsp_length_a;
         got.right_x_b  = rsp_right_x_b;
         got.left_x_b   = rsp_left_x_b;
         got.top_b      = rsp_top_b;
         got.length_b   = rsp_length_b;
         got.span_color = rsp_span_color;
         got.last       = rsp_last;
         spans.check_span(got);
      end
   end

   // start stays high across a burst; the caller lowers it only before a real gap
   task automatic send_request(input int cx, input int cy, input int r, input int col);
      req_center_x <= COORD_W'(cx);
      req_center_y <= COORD_W'(cy);
      req_radius   <= RAD_W'(r);
      req_color    <= COLOR_W'(col);
      start        <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      spans.note_request(cx, cy, r, col);
      circles_sent++;
      if (r == 0) zero_radius_sent++;
      if (r == MAX_RADIUS) full_radius_sent++;
   endtask

   task automatic sender_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (spans.pending() != 0) @(posedge clock);
   endtask

   function automatic int pick_coord();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 70);
         1: return $urandom_range(953, 1023);
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic int pick_radius();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 2);
         1: return MAX_RADIUS;
         2, 3: return $urandom_range(3, 12);
         default: return $urandom_range(0, 63);
      endcase
   endfunction

   initial begin
      int burst_len;
      int gap;
      int sent;
      spans            = new();
      circles_sent     = 0;
      zero_radius_sent = 0;
      full_radius_sent = 0;
      reset            = 1'b1;
      start            = 1'b0;
      req_center_x     = '0;
      req_center_y     = '0;
      req_radius       = '0;
      req_color        = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners, radius extremes, single pixel, color extremes
      send_request(0, 0, 0, 0);
      send_request(1023, 1023, 0, 255);
      send_request(0, 0, 63, 255);
      send_request(1023, 1023, 63, 0);
      sender_gap(3);
      send_request(512, 512, 1, 8'haa);
      send_request(10, 20, 2, 8'h55);
      send_request(0, 1023, 63, 1);
      send_request(1023, 0, 63, 128);
      sender_gap(1);
      send_request(300, 700, 5, 8'h5a);
      send_request(5, 5, 3, 8'ha5);
      send_request(62, 62, 62, 8'h0f);
      send_request(1, 1, 4, 8'hf0);
      send_request(700, 40, 32, 8'h3c);
      send_request(341, 682, 21, 8'hc3);
      wait_drained();
      repeat (5) @(posedge clock);

      sent = 0;
      while (sent < RANDOM_COUNT) begin
         burst_len = $urandom_range(1, 12);
         for (int i = 0; i < burst_len && sent < RANDOM_COUNT; i++) begin
            send_request(pick_coord(), pick_coord(), pick_radius(), $urandom_range(0, 255));
            sent++;
            if (sent == RANDOM_COUNT / 2) break;
         end
         if (sent == RANDOM_COUNT / 2) begin
            wait_drained();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         sender_gap(gap);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d circles (%0d single pixel, %0d at full radius)",
               circles_sent, zero_radius_sent, full_radius_sent);
      $display("%0d span results checked, %0d field mismatches",
               spans.spans_checked, spans.mismatches);
      if (spans.mismatches == 0 && spans.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("timeout with %0d span results outstanding", spans.pending());
      $display("simulation failed");
      $finish;
   end

endmodule
